// ===== rtl/bve_pkg.sv =====
// Shared types, constants and helpers for the bounded vector engine.
// Used by bve_cell and bounded_vector_engine; no dependencies.
package bve_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(CAPACITY);

    typedef struct packed {
        logic              en;
        logic [OP_W-1:0]   op;
        logic [CNT_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] word;
    } t_cell_cmd;

    function automatic logic [CNT_W-1:0] eff_limit(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_W'(CAPACITY)) begin
            r = CNT_W'(CAPACITY);
        end
        return r;
    endfunction

endpackage

// ===== rtl/bve_cell.sv =====
// One storage cell of the list: holds a word, shifts with its neighbors,
// loads a new word and compares against the search word. Uses bve_pkg.
module bve_cell
    import bve_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [WORD_W-1:0] i_prev,
    input  logic [WORD_W-1:0] i_next,
    output logic [WORD_W-1:0] o_entry,
    output logic              o_match
);

    logic [WORD_W-1:0] r_entry;
    logic [WORD_W-1:0] n_entry;
    logic [CNT_W-1:0]  w_idx;

    assign w_idx = {1'b0, i_index};

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.en) begin
            unique case (i_cmd.op)
                OP_APPEND: begin
                    if (w_idx == i_cmd.count) n_entry = i_cmd.word;
                end
                OP_INSERT: begin
                    if (w_idx == i_cmd.pos) begin
                        n_entry = i_cmd.word;
                    end else if (w_idx > i_cmd.pos && w_idx <= i_cmd.count) begin
                        n_entry = i_prev;
                    end
                end
                OP_REMOVE: begin
                    if (w_idx >= i_cmd.pos && (w_idx + CNT_W'(1)) < i_cmd.count) begin
                        n_entry = i_next;
                    end
                end
                default: n_entry = r_entry;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_cmd.word) && (w_idx < i_cmd.count);

endmodule

// ===== rtl/bounded_vector_engine.sv =====
// Top level of the bounded vector engine: a chain of bve_cell storage cells,
// bounds checks, result formation and the output register. Uses bve_pkg.
//
// Usage: a fixed-capacity ordered list of signed 32-bit words. Each input
// word (i_operation, i_position, i_data_word) is taken on a rising edge with
// i_valid high and o_stall low; it appends, inserts, removes, reads or
// searches. Every input word gives one result word on the output channel,
// taken on a rising edge with o_valid high and i_stall low.
// The accept edge moves the item into the evaluation state, from which its
// result enters the output register. No item is taken during evaluation
// (o_stall high); the cells shift, load and compare in the accept cycle, and
// evaluation encodes the search hit and reads the addressed cell. The next
// item may be taken while a result still waits in the output register; if
// the receiver stalls, evaluation holds until the output register frees.
// i_cfg_we with i_cfg_data writes the capacity limit (0 acts as 1, values
// above 16 act as 16); write it only while the block is idle.
// Reset (i_rst_n low, synchronous): count 0, limit 16, no result pending;
// stored words are undefined until written.
module bounded_vector_engine
    import bve_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [CNT_W-1:0]         i_position,
    input  logic signed [WORD_W-1:0] i_data_word,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_accepted,
    output logic                     o_hit,
    output logic signed [WORD_W-1:0] o_read_value,
    output logic signed [CNT_W-1:0]  o_found_position,
    output logic [CNT_W-1:0]         o_element_count,
    output logic                     o_is_empty,
    output logic                     o_is_full,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic                r_state;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_limit;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [OP_W-1:0]     r_op;
    logic                r_acc;
    logic [IDX_W-1:0]    r_pos;
    logic [CAPACITY-1:0] r_match;

    logic                r_accepted;
    logic                r_hit;
    logic [WORD_W-1:0]   r_read_value;
    logic [CNT_W-1:0]    r_found;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_empty;
    logic                r_full;

    logic                w_in_take;
    logic                w_out_take;
    logic                w_eval_done;
    logic [CNT_W-1:0]    w_lim;
    logic                w_acc;
    t_cell_cmd           w_cmd;
    logic [WORD_W-1:0]   w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic                w_hit;
    logic [WORD_W-1:0]   w_rd;
    logic [CNT_W-1:0]    w_found;

    assign o_stall     = (r_state == ST_EVAL);
    assign w_in_take   = i_valid && !o_stall;
    assign w_out_take  = r_out_valid && !i_stall;
    assign w_eval_done = (r_state == ST_EVAL) && (!r_out_valid || !i_stall);
    assign w_lim       = eff_limit(r_limit);

    always_comb begin
        w_acc   = 1'b0;
        n_count = r_count;
        unique case (i_operation)
            OP_APPEND: begin
                w_acc = r_count < w_lim;
                if (w_acc) n_count = r_count + CNT_W'(1);
            end
            OP_INSERT: begin
                w_acc = (r_count < w_lim) && (i_position <= r_count);
                if (w_acc) n_count = r_count + CNT_W'(1);
            end
            OP_REMOVE: begin
                w_acc = i_position < r_count;
                if (w_acc) n_count = r_count - CNT_W'(1);
            end
            OP_READ:   w_acc = i_position < r_count;
            OP_SEARCH: w_acc = 1'b1;
            default:   w_acc = 1'b0;
        endcase
    end

    assign w_cmd.en    = w_in_take && w_acc;
    assign w_cmd.op    = i_operation;
    assign w_cmd.pos   = i_position;
    assign w_cmd.count = r_count;
    assign w_cmd.word  = i_data_word;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] w_prev;
        logic [WORD_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = i_data_word;
        end else begin : g_mid_prev
            assign w_prev = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_mid_next
            assign w_next = w_entry[g+1];
        end
        bve_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (IDX_W'(g)),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    always_comb begin
        w_found = '1;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_match[i]) w_found = CNT_W'(i);
        end
        if (r_op != OP_SEARCH) w_found = '1;
        w_hit = (r_op == OP_READ && r_acc) || (r_op == OP_SEARCH && (|r_match));
        w_rd  = (r_op == OP_READ && r_acc) ? w_entry[r_pos] : '1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (w_in_take) begin
                r_count <= n_count;
                r_state <= ST_EVAL;
            end else if (w_eval_done) begin
                r_state <= ST_IDLE;
            end
            if (w_eval_done) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op    <= i_operation;
            r_acc   <= w_acc;
            r_pos   <= i_position[IDX_W-1:0];
            r_match <= w_match;
        end
        if (w_eval_done) begin
            r_accepted   <= r_acc;
            r_hit        <= w_hit;
            r_read_value <= w_rd;
            r_found      <= w_found;
            r_out_count  <= r_count;
            r_empty      <= (r_count == '0);
            r_full       <= (r_count >= w_lim);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_accepted       = r_accepted;
    assign o_hit            = r_hit;
    assign o_read_value     = r_read_value;
    assign o_found_position = r_found;
    assign o_element_count  = r_out_count;
    assign o_is_empty       = r_empty;
    assign o_is_full        = r_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_take_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state == ST_EVAL))
        else $error("accepted word did not enter evaluation");

    a_eval_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eval_done |=> (o_valid && r_state == ST_IDLE))
        else $error("evaluation finished without a result");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_in_take && $past(i_rst_n)) |=> $stable(r_count))
        else $error("count changed without an accepted word");

endmodule
